// ===== rtl/acf_pkg.sv =====
package acf_pkg;

  localparam int unsigned ALPHA_W   = 17;
  localparam int unsigned FEAT_W    = 24;
  localparam int unsigned SUM_W     = 24;
  localparam int unsigned PROD_W    = ALPHA_W + 1 + FEAT_W;
  localparam int unsigned CONTRIB_W = PROD_W - 16;
  localparam int unsigned MAX_CH    = 4;

  localparam logic [ALPHA_W-1:0] ONE_Q16 = 17'h10000;

  localparam logic signed [CONTRIB_W-1:0] SUM_MAX_W = 26'sd8388607;
  localparam logic signed [CONTRIB_W-1:0] SUM_MIN_W = -26'sd8388608;

  // per-lane pipeline control
  typedef struct packed {
    logic adv;    // pipeline moves this cycle
    logic v1;     // weight stage holds an item
    logic v2;     // contribution stage holds an item
    logic last2;  // item in contribution stage closes the pixel
  } acf_lane_ctl_t;

endpackage

// ===== rtl/acf_if.sv =====
interface acf_in_if import acf_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic                     point_present;
  logic [ALPHA_W-1:0]       alpha;
  logic signed [FEAT_W-1:0] feature_0;
  logic signed [FEAT_W-1:0] feature_1;
  logic signed [FEAT_W-1:0] feature_2;
  logic signed [FEAT_W-1:0] feature_3;
  logic                     last_layer;

  modport source (
    output valid, point_present, alpha, feature_0, feature_1, feature_2, feature_3,
           last_layer,
    input  ready
  );
  modport sink (
    input  valid, point_present, alpha, feature_0, feature_1, feature_2, feature_3,
           last_layer,
    output ready
  );
endinterface

interface acf_out_if import acf_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [SUM_W-1:0] pixel_0;
  logic signed [SUM_W-1:0] pixel_1;
  logic signed [SUM_W-1:0] pixel_2;
  logic signed [SUM_W-1:0] pixel_3;

  modport source (
    output valid, pixel_0, pixel_1, pixel_2, pixel_3,
    input  ready
  );
  modport sink (
    input  valid, pixel_0, pixel_1, pixel_2, pixel_3,
    output ready
  );
endinterface

// ===== rtl/acf_weight.sv =====
module acf_weight import acf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic               present_i,
  input  logic               last_i,
  input  logic [ALPHA_W-1:0] alpha_i,
  output logic [ALPHA_W-1:0] weight_o
);

  logic [ALPHA_W-1:0]   trans_q, trans_d;
  logic [ALPHA_W-1:0]   weight_q;
  logic [ALPHA_W-1:0]   a_sat;
  logic [2*ALPHA_W-1:0] w_prod, t_prod;

  assign a_sat  = (alpha_i > ONE_Q16) ? ONE_Q16 : alpha_i;
  assign w_prod = {{ALPHA_W{1'b0}}, trans_q} * {{ALPHA_W{1'b0}}, a_sat};
  assign t_prod = {{ALPHA_W{1'b0}}, trans_q} * {{ALPHA_W{1'b0}}, ONE_Q16 - a_sat};

  always_comb begin
    trans_d = trans_q;
    if (accept_i) begin
      if (last_i) begin
        trans_d = ONE_Q16;
      end else if (present_i) begin
        trans_d = t_prod[16 +: ALPHA_W];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trans_q <= ONE_Q16;
    end else begin
      trans_q <= trans_d;
    end
  end

  // absent layer carries zero weight
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      weight_q <= present_i ? w_prod[16 +: ALPHA_W] : '0;
    end
  end

  assign weight_o = weight_q;

endmodule

// ===== rtl/acf_lane.sv =====
module acf_lane import acf_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  acf_lane_ctl_t            ctl_i,
  input  logic [ALPHA_W-1:0]       weight_i,
  input  logic signed [FEAT_W-1:0] feature_i,
  output logic signed [SUM_W-1:0]  sum_o
);

  logic signed [PROD_W-1:0]    prod;
  logic signed [CONTRIB_W-1:0] contrib_q;
  logic signed [SUM_W-1:0]     sum_q, sum_d;
  logic signed [CONTRIB_W-1:0] sum_w;
  logic signed [SUM_W-1:0]     sum_sat;

  // dropping the low bits floors toward minus infinity
  assign prod = PROD_W'($signed({1'b0, weight_i})) * PROD_W'(feature_i);

  always_ff @(posedge clk_i) begin
    if (ctl_i.adv && ctl_i.v1) begin
      contrib_q <= prod[PROD_W-1:16];
    end
  end

  assign sum_w = {{(CONTRIB_W-SUM_W){sum_q[SUM_W-1]}}, sum_q} + contrib_q;

  always_comb begin
    if (sum_w > SUM_MAX_W) begin
      sum_sat = SUM_MAX_W[SUM_W-1:0];
    end else if (sum_w < SUM_MIN_W) begin
      sum_sat = SUM_MIN_W[SUM_W-1:0];
    end else begin
      sum_sat = sum_w[SUM_W-1:0];
    end
    sum_d = sum_q;
    if (ctl_i.adv && ctl_i.v2) begin
      sum_d = ctl_i.last2 ? '0 : sum_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else begin
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_sat;

endmodule

// ===== rtl/acf_merge.sv =====
module acf_merge import acf_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    load_i,
  input  logic signed [SUM_W-1:0] sum_i [MAX_CH],
  input  logic                    ready_i,
  output logic                    valid_o,
  output logic signed [SUM_W-1:0] pixel_o [MAX_CH]
);

  logic                    valid_q;
  logic signed [SUM_W-1:0] pixel_q [MAX_CH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      pixel_q <= sum_i;
    end
  end

  assign valid_o = valid_q;
  assign pixel_o = pixel_q;

endmodule

// ===== rtl/alpha_composite_front_to_back_top.sv =====
// a last layer passes the weight and contribution stages, then loads the output register
// throughput: one layer per cycle while the input is not stalled, set by the transmittance
//   multiply whose registered result feeds the next layer
// input stalls only while a finished pixel waits and another last layer is behind it
// reset (async, active low): transmittance to one, channel sums to zero, pipe empty
module alpha_composite_front_to_back_top import acf_pkg::*; #(
  parameter int unsigned CHANNELS = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  acf_in_if.sink    in_i,
  acf_out_if.source out_o
);

  // pipeline: weight stage -> per-channel product -> accumulate and merge
  logic                     adv;
  logic                     accept;
  logic                     out_busy;
  logic                     v1_q, last1_q;
  logic                     v2_q, last2_q;
  logic [ALPHA_W-1:0]       w1;
  logic signed [FEAT_W-1:0] feat_in [MAX_CH];
  logic signed [FEAT_W-1:0] feat1_q [MAX_CH];
  logic signed [SUM_W-1:0]  lane_sum [MAX_CH];
  logic signed [SUM_W-1:0]  pixel [MAX_CH];
  logic                     load;
  acf_lane_ctl_t            lane_ctl;

  assign feat_in[0] = in_i.feature_0;
  assign feat_in[1] = in_i.feature_1;
  assign feat_in[2] = in_i.feature_2;
  assign feat_in[3] = in_i.feature_3;

  // whole pipe holds only when a closing item meets a full, untaken output
  assign out_busy = out_o.valid && !out_o.ready;
  assign adv      = !(v2_q && last2_q && out_busy);
  assign in_i.ready = adv;
  assign accept   = in_i.valid && adv;
  assign load     = adv && v2_q && last2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      last1_q <= 1'b0;
      v2_q    <= 1'b0;
      last2_q <= 1'b0;
    end else if (adv) begin
      v1_q    <= accept;
      last1_q <= accept && in_i.last_layer;
      v2_q    <= v1_q;
      last2_q <= last1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      feat1_q <= feat_in;
    end
  end

  // transmittance recurrence and per-layer weight
  acf_weight u_weight (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .present_i (in_i.point_present),
    .last_i    (in_i.last_layer),
    .alpha_i   (in_i.alpha),
    .weight_o  (w1)
  );

  assign lane_ctl = '{adv: adv, v1: v1_q, v2: v2_q, last2: last2_q};

  // one lane per active channel, unused channels read as zero
  for (genvar c = 0; c < MAX_CH; c++) begin : g_lane
    if (c < CHANNELS) begin : g_on
      acf_lane u_lane (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .ctl_i     (lane_ctl),
        .weight_i  (w1),
        .feature_i (feat1_q[c]),
        .sum_o     (lane_sum[c])
      );
    end else begin : g_off
      assign lane_sum[c] = '0;
    end
  end

  // output register gathers the lane sums of a finished pixel
  acf_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (load),
    .sum_i   (lane_sum),
    .ready_i (out_o.ready),
    .valid_o (out_o.valid),
    .pixel_o (pixel)
  );

  assign out_o.pixel_0 = pixel[0];
  assign out_o.pixel_1 = pixel[1];
  assign out_o.pixel_2 = pixel[2];
  assign out_o.pixel_3 = pixel[3];

  // input is refused only behind a pending pixel
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (out_o.valid && !out_o.ready))
    else $error("input stalled without a pending pixel");

  // a closing item that moves always lands in the output register
  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && v2_q && last2_q) |=> out_o.valid)
    else $error("closing item lost");

  // weight of a valid layer never exceeds one
  a_weight_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q |-> (w1 <= ONE_Q16))
    else $error("weight above one");

endmodule
